// File: rtl/core/rqd_pkg.sv
package rqd_pkg;

    // Policy register codes
    localparam logic [1:0] POL_FIFO = 2'd0;
    localparam logic [1:0] POL_EDF  = 2'd1;
    localparam logic [1:0] POL_RM   = 2'd2;

    // Operation codes
    localparam logic OP_ENQ  = 1'b0;
    localparam logic OP_DISP = 1'b1;

    typedef struct packed {
        logic        op;
        logic [1:0]  task_id;
        logic [31:0] deadline;
        logic [31:0] period;
    } in_item_t;

    typedef struct packed {
        logic       dispatched;
        logic [1:0] chosen_task;
        logic [2:0] queue_count;
        logic       overflow;
    } out_item_t;

    typedef struct packed {
        logic [1:0]  task_id;
        logic [31:0] deadline;
        logic [31:0] period;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH_RD,
        ST_SRCH_CMP,
        ST_SH_RD,
        ST_SH_WR,
        ST_DONE
    } state_t;

endpackage

// File: rtl/core/ready_queue_dispatcher_top.sv
// Ready queue dispatcher: task entries held in arrival order in a small RAM.
// Input channel (in_valid / in_stall) carries one item: op selects enqueue
// or dispatch; task_id, deadline and period are used by enqueue only.
// Output channel (out_valid / out_stall) returns exactly one result per item:
// dispatched flag, chosen task id, queue count after the item, overflow flag.
// Config channel (cfg_valid / cfg_ready) writes the 2-bit policy register:
// first in first out, earliest deadline or shortest period (code 3 acts as
// first in first out). Write it only while the block is idle.
// Enqueue, and dispatch on an empty queue, go straight to the result. A
// dispatch first searches: first in first out reads only the head entry,
// deadline or period reads all N queued entries. It then closes the gap
// behind the chosen entry by moving each later entry down one place.
// The search reads each entry in a read state and a compare state, through
// the single RAM read port and one comparator; closing the gap moves each
// entry in a read state and a write state.
// One item is in work at a time: in_stall is high until the result is loaded,
// so the block takes no new item before it has finished the last one.
// A finished result waits in the output register while out_stall is high;
// the next item is taken meanwhile but its result waits for that slot.
// Reset empties the queue and sets the policy to first in first out.
module ready_queue_dispatcher_top #(
    parameter int MAX_TASKS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  rqd_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  logic                out_stall,
    output rqd_pkg::out_item_t  out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_data
);

    import rqd_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);

    logic [1:0]       policy_reg;
    logic             out_valid_reg;
    out_item_t        out_data_reg;

    logic             idle;
    logic             res_valid;
    logic             res_take;
    out_item_t        res;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    entry_t           ram_wdata;
    entry_t           ram_rdata;

    assign cfg_ready = 1'b1;
    assign in_stall  = !idle;
    assign res_take  = !out_valid_reg || !out_stall;

    // Hold the policy register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POL_FIFO;
        end
        else if (cfg_valid && cfg_ready)
        begin
            policy_reg <= cfg_data;
        end
    end

    // Output register: load a finished result, drop it after the transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_valid && res_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    rqd_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (in_valid && !in_stall),
        .item      (in_data),
        .policy    (policy_reg),
        .res_take  (res_take),
        .idle      (idle),
        .res_valid (res_valid),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    rqd_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    // A transfer starts work, so the input is busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input not stalled after transfer");

    // A result never reports both a dispatch and a dropped enqueue
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(out_data.dispatched && out_data.overflow))
        else $error("dispatch and overflow in one result");

    // No task id without a dispatch
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.dispatched |-> out_data.chosen_task == 2'd0)
        else $error("task id reported without dispatch");

    // A new result is loaded only into a free or draining output register
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("pending result overwritten");
`endif

endmodule

// File: rtl/core/rqd_ram.sv
module rqd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/rqd_ctrl.sv
module rqd_ctrl #(
    parameter int MAX_TASKS = 4
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  rqd_pkg::in_item_t            item,
    input  logic [1:0]                   policy,
    input  logic                         res_take,
    output logic                         idle,
    output logic                         res_valid,
    output rqd_pkg::out_item_t           res,
    output logic                         ram_we,
    output logic [$clog2(MAX_TASKS)-1:0] ram_waddr,
    output rqd_pkg::entry_t              ram_wdata,
    output logic [$clog2(MAX_TASKS)-1:0] ram_raddr,
    input  rqd_pkg::entry_t              ram_rdata
);

    import rqd_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] lim_reg, lim_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [31:0]      best_key_reg, best_key_next;
    logic [1:0]       best_task_reg, best_task_next;
    logic             disp_reg, disp_next;
    logic             ovf_reg, ovf_next;

    logic [CNT_W:0]   idx_inc;
    logic [31:0]      key;
    logic             take;
    logic [CNT_W+2:0] count_ext;

    assign idx_inc   = {1'b0, idx_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign count_ext = {3'b000, count_reg};

    // Shared compare unit: key of the entry just read against the running best
    always_comb
    begin
        unique case (policy)
            POL_EDF: key = ram_rdata.deadline;
            POL_RM:  key = ram_rdata.period;
            default: key = 32'd0;
        endcase
    end
    assign take = (idx_reg == '0) || (key < best_key_reg);

    // State and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        lim_reg       <= lim_next;
        best_idx_reg  <= best_idx_next;
        best_key_reg  <= best_key_next;
        best_task_reg <= best_task_next;
        disp_reg      <= disp_next;
        ovf_reg       <= ovf_next;
    end

    // Sequencer: append, search each entry in a read and a compare state, then close the gap
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        lim_next       = lim_reg;
        best_idx_next  = best_idx_reg;
        best_key_next  = best_key_reg;
        best_task_next = best_task_reg;
        disp_next      = disp_reg;
        ovf_next       = ovf_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[IDX_W-1:0];
        ram_wdata      = '{task_id: item.task_id, deadline: item.deadline,
                           period: item.period};
        ram_raddr      = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    disp_next = 1'b0;
                    ovf_next  = 1'b0;
                    idx_next  = '0;
                    if (item.op == OP_ENQ)
                    begin
                        state_next = ST_DONE;
                        if (count_reg < MAX_CNT)
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SRCH_RD;
                        lim_next   = (policy == POL_EDF || policy == POL_RM) ?
                                     count_reg : CNT_W'(1);
                    end
                end
            end

            ST_SRCH_RD:
            begin
                state_next = ST_SRCH_CMP;
            end

            ST_SRCH_CMP:
            begin
                if (take)
                begin
                    best_idx_next  = idx_reg[IDX_W-1:0];
                    best_key_next  = key;
                    best_task_next = ram_rdata.task_id;
                end
                if (idx_inc < {1'b0, lim_reg})
                begin
                    idx_next   = idx_inc[CNT_W-1:0];
                    state_next = ST_SRCH_RD;
                end
                else
                begin
                    idx_next   = take ? idx_reg : CNT_W'(best_idx_reg);
                    state_next = ST_SH_RD;
                end
            end

            ST_SH_RD:
            begin
                ram_raddr = idx_inc[IDX_W-1:0];
                if (idx_inc < {1'b0, count_reg})
                begin
                    state_next = ST_SH_WR;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                    disp_next  = 1'b1;
                    state_next = ST_DONE;
                end
            end

            ST_SH_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[IDX_W-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_inc[CNT_W-1:0];
                state_next = ST_SH_RD;
            end

            ST_DONE:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle            = (state_reg == ST_IDLE);
    assign res_valid       = (state_reg == ST_DONE);
    assign res.dispatched  = disp_reg;
    assign res.chosen_task = disp_reg ? best_task_reg : 2'd0;
    assign res.queue_count = count_ext[2:0];
    assign res.overflow    = ovf_reg;

endmodule

// File: dv/ready_queue_dispatcher_top_tb.sv
`timescale 1ns / 100ps

module ready_queue_dispatcher_top_tb;

    import rqd_pkg::*;

    localparam int QUEUE_DEPTH = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SEGMENTS    = 12;
    localparam int SEG_ITEMS   = 96;
    localparam int MAX_REPORTS = 40;
    localparam int SETTLE      = 24;

    // Spare policy code, decoded by the block as first in first out
    localparam logic [1:0] POL_SPARE = 2'd3;

    // Ready queue predictor and result checker
    class dispatch_scoreboard;
        entry_t     ready_q[$];
        out_item_t  pending[$];
        logic [1:0] policy;
        int         errors;
        int         reported;

        function new();
            ready_q.delete();
            pending.delete();
            policy   = POL_FIFO;
            errors   = 0;
            reported = 0;
        endfunction

        // Pick the entry a dispatch removes; ties go toward the head
        function int select_entry();
            int best;
            best = 0;
            for (int i = 1; i < ready_q.size(); i++)
            begin
                if (policy == POL_EDF && ready_q[i].deadline < ready_q[best].deadline)
                    best = i;
                else if (policy == POL_RM && ready_q[i].period < ready_q[best].period)
                    best = i;
            end
            return best;
        endfunction

        // Apply one accepted item and queue its expected result
        function void note_item(in_item_t item);
            out_item_t res;
            entry_t    ent;
            int        pick;
            res = '0;
            if (item.op == OP_ENQ)
            begin
                if (ready_q.size() < QUEUE_DEPTH)
                begin
                    ent.task_id  = item.task_id;
                    ent.deadline = item.deadline;
                    ent.period   = item.period;
                    ready_q.push_back(ent);
                end
                else
                    res.overflow = 1'b1;
            end
            else if (ready_q.size() > 0)
            begin
                pick = select_entry();
                res.dispatched  = 1'b1;
                res.chosen_task = ready_q[pick].task_id;
                ready_q.delete(pick);
            end
            res.queue_count = 3'(ready_q.size());
            pending.push_back(res);
        endfunction

        function void flag(string field, logic [31:0] exp_val, logic [31:0] act_val);
            errors++;
            if (reported < MAX_REPORTS)
            begin
                reported++;
                $display("%0t: %s expected %0h actual %0h", $time, field, exp_val, act_val);
            end
        endfunction

        // Compare one accepted result against the oldest expectation
        function void check_result(out_item_t got);
            out_item_t exp_res;
            if (pending.size() == 0)
            begin
                flag("unexpected result", '0, got);
                return;
            end
            exp_res = pending.pop_front();
            if (got.dispatched !== exp_res.dispatched)
                flag("dispatched", exp_res.dispatched, got.dispatched);
            if (got.chosen_task !== exp_res.chosen_task)
                flag("chosen_task", exp_res.chosen_task, got.chosen_task);
            if (got.queue_count !== exp_res.queue_count)
                flag("queue_count", exp_res.queue_count, got.queue_count);
            if (got.overflow !== exp_res.overflow)
                flag("overflow", exp_res.overflow, got.overflow);
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned cycles;

    dispatch_scoreboard sb;

    ready_queue_dispatcher_top #(
        .MAX_TASKS (QUEUE_DEPTH)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Stall the result channel at random
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < rx_idle_pct);

    // Check every result transfer
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("ready_queue_dispatcher_top: mismatch");
            $finish;
        end
    end

    // Drive one item, idling first at random, and hold it until transfer
    task automatic send_item(in_item_t item);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        sb.note_item(item);
    endtask

    task automatic send_fields(logic op, logic [1:0] id, logic [31:0] dl, logic [31:0] per);
        in_item_t item;
        item.op       = op;
        item.task_id  = id;
        item.deadline = dl;
        item.period   = per;
        send_item(item);
    endtask

    // Hold the sender off until every expected result has come back
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_policy(logic [1:0] pol);
        drain();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= pol;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.policy = pol;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Sort keys: small values for ties, corner values, or full range
    function automatic logic [31:0] pick_key();
        case ($urandom_range(2))
            0: return $urandom_range(7);
            1:
            begin
                case ($urandom_range(3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFF;
                    2: return 32'h8000_0000;
                    default: return 32'h7FFF_FFFF;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t make_item(int unsigned enq_pct);
        in_item_t item;
        item.op       = ($urandom_range(99) < enq_pct) ? OP_ENQ : OP_DISP;
        item.task_id  = 2'($urandom_range(3));
        item.deadline = pick_key();
        item.period   = pick_key();
        return item;
    endfunction

    initial
    begin
        int unsigned enq_pct;

        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = POL_FIFO;
        cycles      = 0;
        tx_idle_pct = 29;
        rx_idle_pct = 72;
        sb          = new();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // First in first out: empty dispatch, corner fields, overflow, full drain
        write_policy(POL_FIFO);
        send_fields(OP_DISP, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_fields(OP_ENQ, 2'd0, 32'h0000_0000, 32'hFFFF_FFFF);
        send_fields(OP_ENQ, 2'd3, 32'hFFFF_FFFF, 32'h0000_0000);
        send_fields(OP_ENQ, 2'd1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_fields(OP_ENQ, 2'd2, 32'h7FFF_FFFF, 32'h8000_0000);
        send_fields(OP_ENQ, 2'd3, 32'h0000_0001, 32'h0000_0001);
        repeat (5)
            send_fields(OP_DISP, 2'd2, 32'h5555_5555, 32'hAAAA_AAAA);

        // Earliest deadline with a tie on the least deadline
        write_policy(POL_EDF);
        send_fields(OP_ENQ, 2'd1, 32'd5, 32'd9);
        send_fields(OP_ENQ, 2'd2, 32'd3, 32'd9);
        send_fields(OP_ENQ, 2'd3, 32'd3, 32'd2);
        repeat (3)
            send_fields(OP_DISP, 2'd0, 32'd0, 32'd0);

        // Shortest period with a tie on the least period
        write_policy(POL_RM);
        send_fields(OP_ENQ, 2'd0, 32'd0, 32'd10);
        send_fields(OP_ENQ, 2'd1, 32'd0, 32'd4);
        send_fields(OP_ENQ, 2'd2, 32'd0, 32'd4);
        repeat (3)
            send_fields(OP_DISP, 2'd0, 32'd0, 32'd0);

        // Random segments: every policy under each idling mix
        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg / 4)
                0:
                begin
                    tx_idle_pct = 29;
                    rx_idle_pct = 72;
                end
                1:
                begin
                    tx_idle_pct = 72;
                    rx_idle_pct = 29;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            case (seg % 4)
                0: write_policy(POL_FIFO);
                1: write_policy(POL_EDF);
                2: write_policy(POL_RM);
                default: write_policy(POL_SPARE);
            endcase
            enq_pct = $urandom_range(40, 62);
            for (int n = 0; n < SEG_ITEMS; n++)
                send_item(make_item(enq_pct));
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("ready_queue_dispatcher_top: match");
        else
            $display("ready_queue_dispatcher_top: mismatch");
        $finish;
    end

endmodule
